[design/iaid_pkg.sv]
// Package for the indexed array insert/delete unit.
// Holds field widths, command, status and datapath operation codes, and the
// command/status structs shared by the controller and the datapath.
`default_nettype none

package iaid_pkg;

   // Fixed field widths of the channel beats.
   localparam int unsigned CMD_W  = 2;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned POS_W  = 7;
   localparam int unsigned ST_W   = 2;
   localparam int unsigned SLOT_W = 6;

   // Default number of array entries; the slot field limits it to 64.
   localparam int unsigned DEPTH_DEFAULT = 64;

   // Request commands.
   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT  = 2'd0,
      CMD_DELETE  = 2'd1,
      CMD_UPDATE  = 2'd2,
      CMD_DISPLAY = 2'd3
   } cmd_type;

   // Response status codes.
   typedef enum logic [ST_W-1:0] {
      ST_OK        = 2'd0,
      ST_BAD_INDEX = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } rsp_status_type;

   // Operations the controller issues to the datapath.
   typedef enum logic [2:0] {
      OP_NONE   = 3'd0,
      OP_INSERT = 3'd1,
      OP_DELETE = 3'd2,
      OP_UPDATE = 3'd3,
      OP_STATUS = 3'd4,
      OP_READ   = 3'd5
   } dp_op_type;

   // Controller to datapath command.
   typedef struct packed {
      dp_op_type           op;
      logic [SLOT_W-1:0]   read_slot;
      rsp_status_type      status;
      logic                last;
   } dp_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic              ins_ok;
      logic              idx_ok;
      logic              full;
      logic              empty;
      logic [POS_W-1:0]  count;
   } dp_sts_type;

endpackage

`default_nettype wire

[design/iaid_if.sv]
// Channel interfaces of the indexed array insert/delete unit.
// The request and response channels use valid/ready; widths come from iaid_pkg.
`default_nettype none

interface iaid_req_if;
   logic                          valid;
   logic                          ready;
   logic [iaid_pkg::CMD_W-1:0]    command;
   logic signed [iaid_pkg::DATA_W-1:0] value;
   logic [iaid_pkg::POS_W-1:0]    position;

   modport source (output valid, command, value, position, input ready);
   modport sink   (input valid, command, value, position, output ready);
endinterface

interface iaid_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [iaid_pkg::ST_W-1:0]     status;
   logic signed [iaid_pkg::DATA_W-1:0] data;
   logic [iaid_pkg::SLOT_W-1:0]   slot;
   logic                          last;

   modport source (output valid, status, data, slot, last, input ready);
   modport sink   (input valid, status, data, slot, last, output ready);
endinterface

`default_nettype wire

[design/iaid_datapath.sv]
// Datapath of the indexed array insert/delete unit: a row of entry cells that
// shift in parallel, the entry count and the response beat register.
// Depends on iaid_pkg.
`default_nettype none

module iaid_datapath #(
   parameter int unsigned DEPTH = iaid_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  iaid_pkg::dp_cmd_type               cmd,
   input  logic signed [iaid_pkg::DATA_W-1:0] req_value,
   input  logic [iaid_pkg::POS_W-1:0]         req_position,
   output iaid_pkg::dp_sts_type               sts,
   output logic [iaid_pkg::ST_W-1:0]          rsp_status,
   output logic signed [iaid_pkg::DATA_W-1:0] rsp_data,
   output logic [iaid_pkg::SLOT_W-1:0]        rsp_slot,
   output logic                               rsp_last
);
   import iaid_pkg::*;

   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] cells_ff [DEPTH];
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [IDX_W-1:0]  pos_idx;
   logic [IDX_W-1:0]  rd_idx;
   logic [DATA_W-1:0] rd_data;
   logic [POS_W-1:0]  count_ext;

   logic [ST_W-1:0]   status_ff;
   logic [ST_W-1:0]   status_in;
   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic [SLOT_W-1:0] slot_ff;
   logic [SLOT_W-1:0] slot_in;
   logic              last_ff;
   logic              last_in;

   // The position only indexes the cells after it has been checked in range.
   assign pos_idx   = req_position[IDX_W-1:0];
   assign count_ext = POS_W'(count_ff);

   // Range checks reported to the controller.
   assign sts.ins_ok = (req_position <= count_ext);
   assign sts.idx_ok = (req_position < count_ext);
   assign sts.full   = (count_ff == CNT_W'(DEPTH));
   assign sts.empty  = (count_ff == '0);
   assign sts.count  = count_ext;

   // Single read port: display beats read the streamed slot, otherwise the position.
   assign rd_idx  = (cmd.op == OP_READ) ? cmd.read_slot[IDX_W-1:0] : pos_idx;
   assign rd_data = cells_ff[rd_idx];

   // Each cell takes its own value, its lower or upper neighbor, or the new value.
   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
      localparam int unsigned PREV = (gi == 0) ? 0 : gi - 1;
      localparam int unsigned NEXT = (gi == DEPTH - 1) ? gi : gi + 1;
      logic [DATA_W-1:0] cell_in;

      always_comb begin
         cell_in = cells_ff[gi];
         unique case (cmd.op)
            OP_INSERT: begin
               if (IDX_W'(gi) == pos_idx) begin
                  cell_in = req_value;
               end else if (IDX_W'(gi) > pos_idx) begin
                  cell_in = cells_ff[PREV];
               end
            end
            OP_DELETE: begin
               if (IDX_W'(gi) >= pos_idx) begin
                  cell_in = cells_ff[NEXT];
               end
            end
            OP_UPDATE: begin
               if (IDX_W'(gi) == pos_idx) begin
                  cell_in = req_value;
               end
            end
            default: begin
               cell_in = cells_ff[gi];
            end
         endcase
      end

      always_ff @(posedge clock) begin
         cells_ff[gi] <= cell_in;
      end
   end

   // Entry count follows inserts and deletes.
   always_comb begin
      count_in = count_ff;
      unique case (cmd.op)
         OP_INSERT: count_in = count_ff + CNT_W'(1);
         OP_DELETE: count_in = count_ff - CNT_W'(1);
         default:   count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Response beat register, loaded whenever an operation is issued.
   always_comb begin
      status_in = status_ff;
      data_in   = data_ff;
      slot_in   = slot_ff;
      last_in   = last_ff;
      unique case (cmd.op)
         OP_INSERT: begin
            status_in = ST_OK;
            data_in   = req_value;
            slot_in   = SLOT_W'(pos_idx);
            last_in   = 1'b1;
         end
         OP_DELETE, OP_UPDATE: begin
            status_in = ST_OK;
            data_in   = rd_data;
            slot_in   = SLOT_W'(pos_idx);
            last_in   = 1'b1;
         end
         OP_READ: begin
            status_in = ST_OK;
            data_in   = rd_data;
            slot_in   = cmd.read_slot;
            last_in   = cmd.last;
         end
         OP_STATUS: begin
            status_in = cmd.status;
            data_in   = '0;
            slot_in   = '0;
            last_in   = 1'b1;
         end
         default: begin
            status_in = status_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      data_ff   <= data_in;
      slot_ff   <= slot_in;
      last_ff   <= last_in;
   end

   assign rsp_status = status_ff;
   assign rsp_data   = data_ff;
   assign rsp_slot   = slot_ff;
   assign rsp_last   = last_ff;

endmodule

`default_nettype wire

[design/iaid_ctrl.sv]
// Controller of the indexed array insert/delete unit: handshakes, command
// decode, range checks and the display beat sequencer.
// Depends on iaid_pkg.
`default_nettype none

module iaid_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [iaid_pkg::CMD_W-1:0]  req_command,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  iaid_pkg::dp_sts_type        sts,
   output iaid_pkg::dp_cmd_type        cmd
);
   import iaid_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_RESP = 3'b010,
      S_DISP = 3'b100
   } state_type;

   state_type          state_ff;
   state_type          state_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [POS_W-1:0]   disp_idx_ff;
   logic [POS_W-1:0]   disp_idx_in;
   logic               out_free;
   logic               accept;
   cmd_type            req_cmd;

   assign req_cmd  = cmd_type'(req_command);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = ((state_ff == S_IDLE) || (state_ff == S_RESP)) && out_free;
   assign accept   = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state, datapath command and display index.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      disp_idx_in  = disp_idx_ff;
      cmd.op        = OP_NONE;
      cmd.read_slot = '0;
      cmd.status    = ST_OK;
      cmd.last      = 1'b1;

      unique case (state_ff)
         S_IDLE, S_RESP: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               state_in     = S_RESP;
               unique case (req_cmd)
                  CMD_INSERT: begin
                     if (!sts.ins_ok) begin
                        cmd.op     = OP_STATUS;
                        cmd.status = ST_BAD_INDEX;
                     end else if (sts.full) begin
                        cmd.op     = OP_STATUS;
                        cmd.status = ST_FULL;
                     end else begin
                        cmd.op = OP_INSERT;
                     end
                  end
                  CMD_DELETE, CMD_UPDATE: begin
                     if (!sts.idx_ok) begin
                        cmd.op     = OP_STATUS;
                        cmd.status = ST_BAD_INDEX;
                     end else begin
                        cmd.op = (req_cmd == CMD_DELETE) ? OP_DELETE : OP_UPDATE;
                     end
                  end
                  CMD_DISPLAY: begin
                     if (sts.empty) begin
                        cmd.op     = OP_STATUS;
                        cmd.status = ST_EMPTY;
                     end else begin
                        // First display beat; the rest stream from the DISP state.
                        cmd.op      = OP_READ;
                        cmd.last    = (sts.count == POS_W'(1));
                        disp_idx_in = POS_W'(1);
                        if (sts.count != POS_W'(1)) begin
                           state_in = S_DISP;
                        end
                     end
                  end
                  default: begin
                     cmd.op = OP_NONE;
                  end
               endcase
            end else if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         S_DISP: begin
            // Load the next entry each time the current beat is taken.
            if (rsp_ready) begin
               cmd.op        = OP_READ;
               cmd.read_slot = disp_idx_ff[SLOT_W-1:0];
               cmd.last      = ((disp_idx_ff + POS_W'(1)) == sts.count);
               disp_idx_in   = disp_idx_ff + POS_W'(1);
               if (cmd.last) begin
                  state_in = S_RESP;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         disp_idx_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         disp_idx_ff  <= disp_idx_in;
      end
   end

   // A beat is pending exactly when the controller is not idle.
   a_valid_matches_state: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) == !rsp_valid_ff)
      else $error("response valid disagrees with controller state");

   // No request is taken while a display is streaming.
   a_no_accept_in_display: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DISP) |-> !req_ready)
      else $error("request accepted during display");

   // Every accepted request presents a beat in the next cycle.
   a_accept_gives_beat: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no response beat");

   // The streamed slot stays inside the filled part of the array.
   a_disp_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DISP) |-> (disp_idx_ff < sts.count))
      else $error("display index beyond entry count");

endmodule

`default_nettype wire

[design/indexed_array_insert_delete_unit.sv]
// Top level of the indexed array insert/delete unit.
// Joins iaid_ctrl and iaid_datapath to the iaid_req_if and iaid_rsp_if channels.
//
// Usage:
//   req_chan carries one request per beat: command (insert, delete, update,
//   display), a signed 32-bit value and a 7-bit position. rsp_chan returns
//   response beats: status, data, slot and last, where last marks the final
//   beat of a request.
//   Insert, delete and update complete in the cycle the request is accepted;
//   every entry cell shifts at once. Their single response beat is valid in the
//   cycle after acceptance. A new request is accepted in the same cycle the
//   pending beat is taken, so with rsp_chan.ready held high one such request
//   passes per cycle.
//   Display produces one beat per cycle for count entries while rsp_chan.ready
//   is high (one empty-status beat on an empty array), read through the single
//   read port of the cells; no request is accepted until its final beat is
//   taken. Reset empties the array (count zero) and clears any pending beat;
//   entry contents are not cleared. When rsp_chan.ready is low the pending
//   beat holds and req_chan.ready stays low.
`default_nettype none

module indexed_array_insert_delete_unit #(
   parameter int unsigned DEPTH = iaid_pkg::DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   iaid_req_if.sink     req_chan,
   iaid_rsp_if.source   rsp_chan
);
   import iaid_pkg::*;

   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;

   // Controller: handshakes and operation sequencing.
   iaid_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_command (req_chan.command),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .sts         (dp_sts),
      .cmd         (dp_cmd)
   );

   // Datapath: entry cells, count and response beat register.
   iaid_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (dp_cmd),
      .req_value    (req_chan.value),
      .req_position (req_chan.position),
      .sts          (dp_sts),
      .rsp_status   (rsp_chan.status),
      .rsp_data     (rsp_chan.data),
      .rsp_slot     (rsp_chan.slot),
      .rsp_last     (rsp_chan.last)
   );

endmodule

`default_nettype wire

[dv/indexed_array_insert_delete_unit_tb.sv]
// Testbench for indexed_array_insert_delete_unit: directed table, then random requests.
// Every response beat is checked against an in-bench model of the entry array.
// Depends on iaid_pkg, iaid_req_if and iaid_rsp_if from the design folder.
`timescale 1ns / 100ps

module indexed_array_insert_delete_unit_tb;
   import iaid_pkg::*;

   localparam int unsigned DEPTH      = DEPTH_DEFAULT;
   localparam int unsigned RAND_ITEMS = 320;
   localparam int unsigned DIR_ROWS   = 25;
   localparam int unsigned MAX_SHOWN  = 10;
   localparam int unsigned DRAIN_WAIT = 20;

   // One response beat as the array model expects it.
   typedef struct packed {
      rsp_status_type      status;
      logic [DATA_W-1:0]   data;
      logic [SLOT_W-1:0]   slot;
      logic                last;
   } array_beat_type;

   // One row of the directed table; typed rows carry their expected beat.
   typedef struct packed {
      cmd_type             cmd;
      logic [DATA_W-1:0]   value;
      logic [POS_W-1:0]    pos;
      logic                fill;
      logic                typed;
      array_beat_type      beat;
   } dir_row_type;

   logic clock;
   logic reset;

   iaid_req_if req_chan ();
   iaid_rsp_if rsp_chan ();

   indexed_array_insert_delete_unit #(
      .DEPTH (DEPTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Model state of the entry array.
   logic [DATA_W-1:0] model_entries [0:DEPTH-1];
   int unsigned       model_count;

   // Beats still owed by the block, oldest first.
   array_beat_type pending_beats [$];
   int unsigned    fail_count;

   // Directed table: empty array, bad indexes, extremes, fill to full, full cases.
   dir_row_type dir_rows [0:DIR_ROWS-1] = '{
      '{CMD_DISPLAY, 32'h0000_0000, 7'd0,   1'b0, 1'b1, '{ST_EMPTY, 32'h0, 6'd0, 1'b1}},
      '{CMD_DELETE,  32'h0000_0000, 7'd0,   1'b0, 1'b1, '{ST_BAD_INDEX, 32'h0, 6'd0, 1'b1}},
      '{CMD_UPDATE,  32'h0000_0001, 7'd0,   1'b0, 1'b1, '{ST_BAD_INDEX, 32'h0, 6'd0, 1'b1}},
      '{CMD_INSERT,  32'h0000_0001, 7'd1,   1'b0, 1'b1, '{ST_BAD_INDEX, 32'h0, 6'd0, 1'b1}},
      '{CMD_INSERT,  32'h0000_0001, 7'd127, 1'b0, 1'b1, '{ST_BAD_INDEX, 32'h0, 6'd0, 1'b1}},
      '{CMD_INSERT,  32'h8000_0000, 7'd0,   1'b0, 1'b1, '{ST_OK, 32'h8000_0000, 6'd0, 1'b1}},
      '{CMD_INSERT,  32'h7fff_ffff, 7'd1,   1'b0, 1'b1, '{ST_OK, 32'h7fff_ffff, 6'd1, 1'b1}},
      '{CMD_INSERT,  32'h0000_0000, 7'd0,   1'b0, 1'b1, '{ST_OK, 32'h0000_0000, 6'd0, 1'b1}},
      '{CMD_INSERT,  32'hffff_ffff, 7'd1,   1'b0, 1'b1, '{ST_OK, 32'hffff_ffff, 6'd1, 1'b1}},
      '{CMD_DISPLAY, 32'h0000_0000, 7'd0,   1'b0, 1'b0, '{ST_OK, 32'h0, 6'd0, 1'b0}},
      '{CMD_UPDATE,  32'h5a5a_5a5a, 7'd3,   1'b0, 1'b0, '{ST_OK, 32'h0, 6'd0, 1'b0}},
      '{CMD_UPDATE,  32'ha5a5_a5a5, 7'd4,   1'b0, 1'b1, '{ST_BAD_INDEX, 32'h0, 6'd0, 1'b1}},
      '{CMD_DELETE,  32'h0000_0000, 7'd0,   1'b0, 1'b0, '{ST_OK, 32'h0, 6'd0, 1'b0}},
      '{CMD_DELETE,  32'h0000_0000, 7'd3,   1'b0, 1'b1, '{ST_BAD_INDEX, 32'h0, 6'd0, 1'b1}},
      '{CMD_DELETE,  32'h0000_0000, 7'd2,   1'b0, 1'b0, '{ST_OK, 32'h0, 6'd0, 1'b0}},
      '{CMD_DISPLAY, 32'h0000_0000, 7'd0,   1'b0, 1'b0, '{ST_OK, 32'h0, 6'd0, 1'b0}},
      '{CMD_INSERT,  32'h0000_0000, 7'd0,   1'b1, 1'b0, '{ST_OK, 32'h0, 6'd0, 1'b0}},
      '{CMD_INSERT,  32'h1357_9bdf, 7'd64,  1'b0, 1'b1, '{ST_FULL, 32'h0, 6'd0, 1'b1}},
      '{CMD_INSERT,  32'h0000_0001, 7'd0,   1'b0, 1'b1, '{ST_FULL, 32'h0, 6'd0, 1'b1}},
      '{CMD_INSERT,  32'h0000_0001, 7'd65,  1'b0, 1'b1, '{ST_BAD_INDEX, 32'h0, 6'd0, 1'b1}},
      '{CMD_UPDATE,  32'h1234_5678, 7'd63,  1'b0, 1'b0, '{ST_OK, 32'h0, 6'd0, 1'b0}},
      '{CMD_DISPLAY, 32'h0000_0000, 7'd0,   1'b0, 1'b0, '{ST_OK, 32'h0, 6'd0, 1'b0}},
      '{CMD_DELETE,  32'h0000_0000, 7'd63,  1'b0, 1'b0, '{ST_OK, 32'h0, 6'd0, 1'b0}},
      '{CMD_DELETE,  32'h0000_0000, 7'd64,  1'b0, 1'b1, '{ST_BAD_INDEX, 32'h0, 6'd0, 1'b1}},
      '{CMD_INSERT,  32'h2468_ace0, 7'd63,  1'b0, 1'b1, '{ST_OK, 32'h2468_ace0, 6'd63, 1'b1}}
   };

   // Clock with a 2 ns period.
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Run limit, far above the slowest legal run.
   initial begin
      #4_000_000;
      $display("FAIL indexed_array_insert_delete_unit");
      $finish;
   end

   function automatic array_beat_type mk_beat(input rsp_status_type st,
                                              input logic [DATA_W-1:0] data,
                                              input int unsigned slot,
                                              input logic last);
      array_beat_type b;
      b.status = st;
      b.data   = data;
      b.slot   = slot[SLOT_W-1:0];
      b.last   = last;
      return b;
   endfunction

   // Applies one request to the model array and returns the beats it causes.
   function automatic void predict_array_op(input cmd_type cmd,
                                            input logic [DATA_W-1:0] value,
                                            input logic [POS_W-1:0] pos,
                                            ref array_beat_type beats [$]);
      int unsigned       i;
      logic [DATA_W-1:0] old;
      beats.delete();
      case (cmd)
         CMD_INSERT: begin
            // The index check wins over the full check.
            if (pos > model_count) begin
               beats.push_back(mk_beat(ST_BAD_INDEX, '0, 0, 1'b1));
            end else if (model_count >= DEPTH) begin
               beats.push_back(mk_beat(ST_FULL, '0, 0, 1'b1));
            end else begin
               for (i = model_count; i > pos; i--) model_entries[i] = model_entries[i-1];
               model_entries[pos] = value;
               model_count++;
               beats.push_back(mk_beat(ST_OK, value, pos, 1'b1));
            end
         end
         CMD_DELETE: begin
            if (pos >= model_count) begin
               beats.push_back(mk_beat(ST_BAD_INDEX, '0, 0, 1'b1));
            end else begin
               old = model_entries[pos];
               for (i = pos; i + 1 < model_count; i++) model_entries[i] = model_entries[i+1];
               model_count--;
               beats.push_back(mk_beat(ST_OK, old, pos, 1'b1));
            end
         end
         CMD_UPDATE: begin
            if (pos >= model_count) begin
               beats.push_back(mk_beat(ST_BAD_INDEX, '0, 0, 1'b1));
            end else begin
               old = model_entries[pos];
               model_entries[pos] = value;
               beats.push_back(mk_beat(ST_OK, old, pos, 1'b1));
            end
         end
         default: begin
            if (model_count == 0) begin
               beats.push_back(mk_beat(ST_EMPTY, '0, 0, 1'b1));
            end else begin
               for (i = 0; i < model_count; i++)
                  beats.push_back(mk_beat(ST_OK, model_entries[i], i, i + 1 == model_count));
            end
         end
      endcase
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_SHOWN) $display("%0t: %s", $realtime, msg);
   endtask

   // Drives one request beat and waits until it is taken; then books its beats.
   task automatic send_request(input cmd_type cmd, input logic [DATA_W-1:0] value,
                               input logic [POS_W-1:0] pos, input logic typed,
                               input array_beat_type typed_beat);
      array_beat_type beats [$];
      req_chan.valid    <= 1'b1;
      req_chan.command  <= cmd;
      req_chan.value    <= value;
      req_chan.position <= pos;
      do @(posedge clock); while (!req_chan.ready);
      predict_array_op(cmd, value, pos, beats);
      if (typed) pending_beats.push_back(typed_beat);
      else foreach (beats[k]) pending_beats.push_back(beats[k]);
   endtask

   task automatic idle_sender(input int unsigned cycles);
      req_chan.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Holds the sender off until every owed beat has arrived.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_beats.size() != 0) @(posedge clock);
   endtask

   // Receiver back-pressure: modes of random length, one of them with no stalls.
   initial begin : rsp_stall_gen
      int unsigned mode;
      int unsigned mode_left;
      rsp_chan.ready <= 1'b0;
      mode      = 0;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(40, 400);
         end
         mode_left--;
         case (mode)
            0:       rsp_chan.ready <= 1'b1;
            1:       rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_chan.ready <= ($urandom_range(0, 1) == 0);
            default: rsp_chan.ready <= ((mode_left % 8) < 5);
         endcase
      end
   end

   // Checks each taken response beat against the oldest owed beat.
   always @(posedge clock) begin
      array_beat_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_beats.size() == 0) begin
            note_failure($sformatf("unexpected beat: status %0d data %h slot %0d last %0b",
                                   rsp_chan.status, rsp_chan.data, rsp_chan.slot,
                                   rsp_chan.last));
         end else begin
            want = pending_beats.pop_front();
            if (rsp_chan.status !== want.status || rsp_chan.data !== want.data ||
                rsp_chan.slot !== want.slot || rsp_chan.last !== want.last) begin
               note_failure($sformatf(
                  "beat mismatch: expected status %0d data %h slot %0d last %0b, got %0d %h %0d %0b",
                  want.status, want.data, want.slot, want.last,
                  rsp_chan.status, rsp_chan.data, rsp_chan.slot, rsp_chan.last));
            end
         end
      end
   end

   // Main stimulus: reset, directed table, then random requests.
   initial begin : stimulus
      int unsigned   burst_left;
      int unsigned   mode;
      int unsigned   roll;
      int unsigned   k;
      cmd_type       cmd;
      logic [DATA_W-1:0] value;
      logic [POS_W-1:0]  pos;
      array_beat_type    no_beat;

      model_count = 0;
      fail_count  = 0;
      no_beat     = '0;
      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.command  <= CMD_INSERT;
      req_chan.value    <= '0;
      req_chan.position <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part; the fill row inserts at the end until the array is full.
      for (k = 0; k < DIR_ROWS; k++) begin
         if (dir_rows[k].fill) begin
            while (model_count < DEPTH)
               send_request(CMD_INSERT, $urandom, model_count[POS_W-1:0], 1'b0, no_beat);
         end else begin
            send_request(dir_rows[k].cmd, dir_rows[k].value, dir_rows[k].pos,
                         dir_rows[k].typed, dir_rows[k].beat);
         end
         if ($urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 4));
      end
      wait_drained();

      // Random part: phases that grow, shrink or churn the array.
      burst_left = $urandom_range(1, 24);
      mode       = 0;
      for (k = 0; k < RAND_ITEMS; k++) begin
         if (k % 80 == 0) mode = $urandom_range(0, 2);
         if (k == RAND_ITEMS / 2) wait_drained();

         roll = $urandom_range(0, 99);
         if (roll < 4) cmd = CMD_DISPLAY;
         else if (mode == 0) cmd = (roll < 75) ? CMD_INSERT : (roll < 87) ? CMD_DELETE : CMD_UPDATE;
         else if (mode == 1) cmd = (roll < 25) ? CMD_INSERT : (roll < 80) ? CMD_DELETE : CMD_UPDATE;
         else cmd = (roll < 45) ? CMD_INSERT : (roll < 75) ? CMD_DELETE : CMD_UPDATE;

         // Mostly legal indexes, biased to the ends; some out-of-range noise.
         roll = $urandom_range(0, 9);
         if (roll == 0) pos = POS_W'($urandom_range(0, 127));
         else if (cmd == CMD_INSERT)
            pos = POS_W'((roll == 1) ? 0 : (roll == 2) ? model_count
                                                        : $urandom_range(0, model_count));
         else if (model_count == 0) pos = '0;
         else
            pos = POS_W'((roll == 1) ? 0 : (roll == 2) ? model_count - 1
                                                        : $urandom_range(0, model_count - 1));

         roll = $urandom_range(0, 15);
         case (roll)
            0:       value = 32'h8000_0000;
            1:       value = 32'h7fff_ffff;
            2:       value = 32'h0000_0000;
            3:       value = 32'hffff_ffff;
            default: value = $urandom;
         endcase

         send_request(cmd, value, pos, 1'b0, no_beat);

         // Bursts with random gaps; some phases keep the sender busy.
         if (burst_left > 1) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(1, 24);
            if (mode != 2 || $urandom_range(0, 1) == 0) idle_sender($urandom_range(1, 6));
         end
      end
      req_chan.valid <= 1'b0;

      // Let every owed beat arrive, then watch for strays.
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (pending_beats.size() != 0)
         note_failure($sformatf("%0d beats never arrived", pending_beats.size()));

      if (fail_count == 0) begin
         $display("PASS indexed_array_insert_delete_unit");
      end else begin
         $display("FAIL indexed_array_insert_delete_unit");
      end
      $finish;
   end

endmodule

[filelist.f]
design/iaid_pkg.sv
design/iaid_if.sv
design/iaid_datapath.sv
design/iaid_ctrl.sv
design/indexed_array_insert_delete_unit.sv
dv/indexed_array_insert_delete_unit_tb.sv
